### src/idck_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idck_pkg
// Types, character codes and per-character helper functions shared by the
// identity number checksum validator.
// ----------------------------------------------------------------------------
package idck_pkg;

    localparam int unsigned RES_W = 41;
    localparam int unsigned TDATA_OUT_W = 48;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_2     = 8'h32;
    localparam logic [7:0] CHAR_8     = 8'h38;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_UP_O  = 8'h4F;
    localparam logic [7:0] CHAR_LO_O  = 8'h6F;
    localparam logic [7:0] CHAR_UP_I  = 8'h49;
    localparam logic [7:0] CHAR_LO_I  = 8'h69;
    localparam logic [7:0] CHAR_UP_L  = 8'h4C;
    localparam logic [7:0] CHAR_LO_L  = 8'h6C;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_B  = 8'h42;
    localparam logic [7:0] LEAD_BYTE  = 8'hC3;
    localparam logic [7:0] CONT_BYTE  = 8'h97;

    localparam logic [4:0] BODY_LEN   = 5'd17;
    localparam logic [4:0] FULL_LEN   = 5'd18;
    localparam logic [4:0] SAT_MAX    = 5'd31;
    localparam logic [13:0] YEAR_MIN  = 14'd1900;
    localparam logic [13:0] YEAR_MAX  = 14'd2100;
    localparam logic [3:0] CHECK_X    = 4'd10;

    typedef struct packed {
        logic [4:0]  raw_position;
        logic [4:0]  clean_count;
        logic        lead_pending;
        logic        format_broken;
        logic [3:0]  residue;
        logic [7:0]  final_char;
        logic [13:0] year_accum;
        logic [6:0]  month_accum;
        logic [6:0]  day_accum;
        logic        parity_odd;
    } idck_state_t;

    localparam idck_state_t STATE_RESET = '0;

    typedef struct packed {
        logic [4:0]  cleaned_length;
        logic [3:0]  expected_check;
        logic        is_male;
        logic [6:0]  birth_day;
        logic [6:0]  birth_month;
        logic [13:0] birth_year;
        logic        date_valid;
        logic        check_match;
        logic        form_ok;
    } idck_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

    function automatic logic [3:0] weight_of(input logic [4:0] k);
        logic [3:0] w;
        case (k)
            5'd0, 5'd10:  w = 4'd7;
            5'd1, 5'd11:  w = 4'd9;
            5'd2, 5'd12:  w = 4'd10;
            5'd3, 5'd13:  w = 4'd5;
            5'd4, 5'd14:  w = 4'd8;
            5'd5, 5'd15:  w = 4'd4;
            5'd6, 5'd16:  w = 4'd2;
            5'd7:         w = 4'd1;
            5'd8:         w = 4'd6;
            5'd9:         w = 4'd3;
            default:      w = 4'd0;
        endcase
        return w;
    endfunction

    // Reduces a value below 176 modulo 11 by conditional subtraction.
    function automatic logic [3:0] mod11(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd88) r = r - 8'd88;
        if (r >= 8'd44) r = r - 8'd44;
        if (r >= 8'd22) r = r - 8'd22;
        if (r >= 8'd11) r = r - 8'd11;
        return r[3:0];
    endfunction

    function automatic logic [7:0] map_byte(input logic [7:0] c, input logic last);
        logic [7:0] m;
        case (c)
            CHAR_UP_O, CHAR_LO_O:                       m = CHAR_0;
            CHAR_UP_I, CHAR_LO_I, CHAR_UP_L, CHAR_LO_L: m = CHAR_1;
            CHAR_UP_Z, CHAR_LO_Z:                       m = CHAR_2;
            CHAR_UP_B:                                  m = CHAR_8;
            default:                                    m = c;
        endcase
        if (last && (m == CHAR_LO_X)) m = CHAR_UP_X;
        return m;
    endfunction

    function automatic idck_state_t push_clean(input idck_state_t s, input logic [7:0] c);
        idck_state_t n;
        logic [3:0] d;
        logic [7:0] prod;
        n = s;
        d = c[3:0] - CHAR_0[3:0];
        prod = d * weight_of(s.clean_count);
        if (s.clean_count < BODY_LEN) begin
            if (is_digit(c)) begin
                n.residue = mod11(8'(s.residue) + prod);
                if (s.clean_count >= 5'd6 && s.clean_count <= 5'd9) begin
                    n.year_accum = 14'((s.year_accum << 3) + (s.year_accum << 1) + 14'(d));
                end else if (s.clean_count >= 5'd10 && s.clean_count <= 5'd11) begin
                    n.month_accum = 7'((s.month_accum << 3) + (s.month_accum << 1) + 7'(d));
                end else if (s.clean_count >= 5'd12 && s.clean_count <= 5'd13) begin
                    n.day_accum = 7'((s.day_accum << 3) + (s.day_accum << 1) + 7'(d));
                end else if (s.clean_count == 5'd16) begin
                    n.parity_odd = d[0];
                end
            end else begin
                n.format_broken = 1'b1;
            end
        end else if (s.clean_count == BODY_LEN) begin
            n.final_char = c;
        end
        if (s.clean_count < SAT_MAX) n.clean_count = s.clean_count + 5'd1;
        return n;
    endfunction

endpackage
`default_nettype wire

### src/idck_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idck_step
// Cleans one raw byte, folds it into the running state and forms the
// end-of-string result.
// ----------------------------------------------------------------------------
module idck_step (
    input  var idck_pkg::idck_state_t  state_in,
    input  wire logic [7:0]            raw_byte,
    input  wire logic                  end_of_string,
    output idck_pkg::idck_state_t      state_out,
    output idck_pkg::idck_result_t     result
);
    import idck_pkg::*;

    idck_state_t s;
    logic        fmt;
    logic        date_ok;
    logic        check_ok;
    logic [4:0]  raw_diff;
    logic [3:0]  expv;
    logic [3:0]  lastv;

    always_comb begin
        s = state_in;
        s.lead_pending = 1'b0;
        if (state_in.lead_pending && (raw_byte == CONT_BYTE)) begin
            s = push_clean(s, CHAR_UP_X);
        end else begin
            if (state_in.lead_pending) s = push_clean(s, LEAD_BYTE);
            if (raw_byte == LEAD_BYTE) begin
                if (end_of_string) s = push_clean(s, LEAD_BYTE);
                else s.lead_pending = 1'b1;
            end else begin
                s = push_clean(s, map_byte(raw_byte,
                    end_of_string || (state_in.raw_position == BODY_LEN)));
            end
        end
        if (state_in.raw_position < SAT_MAX) s.raw_position = state_in.raw_position + 5'd1;
    end

    assign raw_diff = 5'd12 - 5'(s.residue);
    assign fmt = (s.clean_count == FULL_LEN) && !s.format_broken &&
                 (is_digit(s.final_char) || (s.final_char == CHAR_UP_X));
    assign expv = fmt ? ((raw_diff >= 5'd11) ? 4'(raw_diff - 5'd11) : raw_diff[3:0]) : 4'd0;
    assign lastv = (s.final_char == CHAR_UP_X) ? CHECK_X : 4'(s.final_char - CHAR_0);
    assign check_ok = fmt && (lastv == expv);
    assign date_ok = fmt && (s.year_accum >= YEAR_MIN) && (s.year_accum <= YEAR_MAX) &&
                     (s.month_accum >= 7'd1) && (s.month_accum <= 7'd12) &&
                     (s.day_accum >= 7'd1) && (s.day_accum <= 7'd31);

    always_comb begin
        result.form_ok        = fmt;
        result.check_match    = check_ok;
        result.date_valid     = date_ok;
        result.birth_year     = date_ok ? s.year_accum : 14'd0;
        result.birth_month    = date_ok ? s.month_accum : 7'd0;
        result.birth_day      = date_ok ? s.day_accum : 7'd0;
        result.is_male        = fmt && s.parity_odd;
        result.expected_check = expv;
        result.cleaned_length = s.clean_count;
    end

    assign state_out = end_of_string ? STATE_RESET : s;

endmodule
`default_nettype wire

### src/id_number_checksum_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id_number_checksum_validator
// Streaming validator for 18-character identity numbers with a MOD 11-2
// check character.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle and produces one result transaction
// for each byte marked by s_tlast. A byte passes through an input register and
// then through the cleaning and accumulation logic into the state and result
// registers, and the result register drives the output transaction.
// Bytes that do not end a string keep flowing while a result waits on the
// output; only a final byte is held back while the output register is full.
// ----------------------------------------------------------------------------
module id_number_checksum_validator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // raw_byte
    input  wire logic        s_tlast,   // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // form_ok, check_match, date_valid,
                                        // birth_year, birth_month, birth_day, is_male,
                                        // expected_check, cleaned_length, zero fill
);
    import idck_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_end_reg;
    idck_state_t   state_reg;
    idck_state_t   state_next;
    idck_result_t  result_next;
    logic          out_valid_reg;
    idck_result_t  out_data_reg;
    logic          advance;

    idck_step u_step (
        .state_in      (state_reg),
        .raw_byte      (in_byte_reg),
        .end_of_string (in_end_reg),
        .state_out     (state_next),
        .result        (result_next)
    );

    assign advance  = in_valid_reg && (!in_end_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) state_reg <= state_next;
            if (advance && in_end_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_end_reg) begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - RES_W){1'b0}}, out_data_reg};

endmodule
`default_nettype wire

### bench/id_number_checksum_validator_tb.sv
// ----------------------------------------------------------------------------
// id_number_checksum_validator_tb
// Self-checking bench for the identity number checksum validator. Raw OCR
// bytes are streamed in, a behavioral model predicts each end-of-string
// result, and every result transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module id_number_checksum_validator_tb;
    import idck_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAW_TARGET  = 700;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_item_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'h00;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;

    raw_item_t    stim_q[$];
    idck_result_t results_due[$];
    logic [7:0]   str_q[$];
    int           id_digits[18];
    int           weight_lut[17] = '{7, 9, 10, 5, 8, 4, 2, 1, 6, 3, 7, 9, 10, 5, 8, 4, 2};

    logic [4:0]  raw_pos;
    logic [4:0]  clean_n;
    logic        lead_wait;
    logic        broken;
    logic [3:0]  resid;
    logic [7:0]  tail_char;
    logic [13:0] yr;
    logic [6:0]  mo;
    logic [6:0]  dy;
    logic        odd;

    int        errors = 0;
    int        cycles = 0;
    int        sent_count = 0;
    int        bytes_in = 0;
    int        strings_made = 0;
    int        results_seen = 0;
    int        good_checks = 0;
    int        mark1 = 0;
    int        mark2 = 0;
    logic      in_taken = 1'b0;
    raw_item_t next_item;

    id_number_checksum_validator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR: result %0d, %s: got %0d, expected %0d", results_seen, what, got,
                 want);
        errors++;
    endtask

    task automatic clear_predictor();
        raw_pos   = '0;
        clean_n   = '0;
        lead_wait = 1'b0;
        broken    = 1'b0;
        resid     = '0;
        tail_char = '0;
        yr        = '0;
        mo        = '0;
        dy        = '0;
        odd       = 1'b0;
    endtask

    function automatic logic [7:0] ocr_clean(input logic [7:0] c, input logic tail);
        case (c)
            CHAR_UP_O, CHAR_LO_O:                       return CHAR_0;
            CHAR_UP_I, CHAR_LO_I, CHAR_UP_L, CHAR_LO_L: return CHAR_1;
            CHAR_UP_Z, CHAR_LO_Z:                       return CHAR_2;
            CHAR_UP_B:                                  return CHAR_8;
            default: begin
                if (tail && c == CHAR_LO_X) return CHAR_UP_X;
                return c;
            end
        endcase
    endfunction

    task automatic append_clean_char(input logic [7:0] c);
        int d;
        if (clean_n < BODY_LEN) begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
                d = int'(c) - int'(CHAR_0);
                resid = 4'((int'(resid) + d * weight_lut[clean_n]) % 11);
                if (clean_n >= 6 && clean_n <= 9) yr = 14'(int'(yr) * 10 + d);
                else if (clean_n >= 10 && clean_n <= 11) mo = 7'(int'(mo) * 10 + d);
                else if (clean_n >= 12 && clean_n <= 13) dy = 7'(int'(dy) * 10 + d);
                else if (clean_n == 16) odd = d[0];
            end else begin
                broken = 1'b1;
            end
        end else if (clean_n == BODY_LEN) begin
            tail_char = c;
        end
        if (clean_n < SAT_MAX) clean_n = clean_n + 5'd1;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic tail);
        logic         consumed;
        logic         fmt;
        logic         ck;
        logic         dv;
        logic [3:0]   expv;
        logic [7:0]   lastv;
        idck_result_t r;
        consumed = 1'b0;
        if (lead_wait) begin
            lead_wait = 1'b0;
            if (b == CONT_BYTE) begin
                append_clean_char(CHAR_UP_X);
                consumed = 1'b1;
            end else begin
                append_clean_char(LEAD_BYTE);
            end
        end
        if (!consumed) begin
            if (b == LEAD_BYTE) begin
                if (tail) append_clean_char(LEAD_BYTE);
                else lead_wait = 1'b1;
            end else begin
                append_clean_char(ocr_clean(b, tail || raw_pos == BODY_LEN));
            end
        end
        if (raw_pos < SAT_MAX) raw_pos = raw_pos + 5'd1;
        if (tail) begin
            fmt = (clean_n == FULL_LEN) && !broken &&
                  ((tail_char >= CHAR_0 && tail_char <= CHAR_9) || tail_char == CHAR_UP_X);
            expv  = fmt ? 4'((12 - int'(resid)) % 11) : 4'd0;
            lastv = (tail_char == CHAR_UP_X) ? 8'd10 : 8'(tail_char - CHAR_0);
            ck    = fmt && (lastv == {4'd0, expv});
            dv    = fmt && yr >= YEAR_MIN && yr <= YEAR_MAX && mo >= 7'd1 && mo <= 7'd12 &&
                    dy >= 7'd1 && dy <= 7'd31;
            r.form_ok        = fmt;
            r.check_match    = ck;
            r.date_valid     = dv;
            r.birth_year     = dv ? yr : 14'd0;
            r.birth_month    = dv ? mo : 7'd0;
            r.birth_day      = dv ? dy : 7'd0;
            r.is_male        = fmt ? odd : 1'b0;
            r.expected_check = expv;
            r.cleaned_length = clean_n;
            results_due.insert(results_due.size(), r);
            clear_predictor();
        end
    endtask

    task automatic push_raw(input logic [7:0] b, input logic last);
        raw_item_t it;
        it.data = b;
        it.last = last;
        stim_q.insert(stim_q.size(), it);
    endtask

    task automatic flush_string();
        for (int i = 0; i < str_q.size(); i++) push_raw(str_q[i], i == str_q.size() - 1);
        str_q.delete();
        strings_made++;
    endtask

    function automatic logic [7:0] ocr_variant(input int d);
        case (d)
            0: return $urandom_range(1) ? CHAR_UP_O : CHAR_LO_O;
            1: begin
                case ($urandom_range(3))
                    0:       return CHAR_UP_I;
                    1:       return CHAR_LO_I;
                    2:       return CHAR_UP_L;
                    default: return CHAR_LO_L;
                endcase
            end
            2: return $urandom_range(1) ? CHAR_UP_Z : CHAR_LO_Z;
            8: return CHAR_UP_B;
            default: return 8'(int'(CHAR_0) + d);
        endcase
    endfunction

    task automatic build_id(input bit want_x, input bit sane_date);
        int sum;
        int v;
        do begin
            for (int i = 0; i < 6; i++) id_digits[i] = $urandom_range(9);
            v = sane_date ? $urandom_range(2100, 1900) : $urandom_range(9999);
            id_digits[6] = v / 1000;
            id_digits[7] = (v / 100) % 10;
            id_digits[8] = (v / 10) % 10;
            id_digits[9] = v % 10;
            v = sane_date ? $urandom_range(12, 1) : $urandom_range(99);
            id_digits[10] = v / 10;
            id_digits[11] = v % 10;
            v = sane_date ? $urandom_range(31, 1) : $urandom_range(99);
            id_digits[12] = v / 10;
            id_digits[13] = v % 10;
            for (int i = 14; i < 17; i++) id_digits[i] = $urandom_range(9);
            sum = 0;
            for (int i = 0; i < 17; i++) sum += id_digits[i] * weight_lut[i];
            id_digits[17] = (12 - sum % 11) % 11;
        end while (want_x && id_digits[17] != 10);
    endtask

    task automatic compose_id(input bit noisy, input int x_style);
        str_q.delete();
        for (int i = 0; i < 18; i++) begin
            if (i == 17 && id_digits[i] == 10) begin
                case (x_style)
                    0: str_q.insert(str_q.size(), CHAR_UP_X);
                    1: begin
                        str_q.insert(str_q.size(), LEAD_BYTE);
                        str_q.insert(str_q.size(), CONT_BYTE);
                    end
                    default: str_q.insert(str_q.size(), CHAR_LO_X);
                endcase
            end else if (noisy && $urandom_range(3) == 0) begin
                str_q.insert(str_q.size(), ocr_variant(id_digits[i]));
            end else begin
                str_q.insert(str_q.size(), 8'(int'(CHAR_0) + id_digits[i]));
            end
        end
    endtask

    task automatic corrupt_id();
        int pos;
        int n;
        case ($urandom_range(7))
            0: begin
                id_digits[17] = (id_digits[17] + 1 + $urandom_range(9)) % 11;
                compose_id(1'b1, $urandom_range(2));
            end
            1: str_q.delete($urandom_range(str_q.size() - 1));
            2: str_q.insert($urandom_range(str_q.size()), 8'($urandom_range(255)));
            3: str_q[$urandom_range(16)] = 8'($urandom_range(255));
            4: begin
                n = $urandom_range(20, 1);
                repeat (n) str_q.insert(str_q.size(), 8'($urandom_range(255)));
            end
            5: begin
                pos = $urandom_range(str_q.size() - 1);
                str_q.insert(pos, LEAD_BYTE);
                str_q[pos + 1] = (str_q[pos + 1] == CONT_BYTE) ? CHAR_0 : str_q[pos + 1];
            end
            6: begin
                while (str_q.size() > 17) void'(str_q.pop_back());
                str_q.insert(str_q.size(), CHAR_LO_X);
                n = $urandom_range(3, 1);
                repeat (n) str_q.insert(str_q.size(), 8'($urandom_range(57, 48)));
            end
            default: begin
                n = $urandom_range(40, 32);
                str_q.delete();
                repeat (n) str_q.insert(str_q.size(), ocr_variant($urandom_range(9)));
            end
        endcase
    endtask

    function automatic int send_idle_pct(input int sent);
        if (sent < mark1) return 36;
        if (sent < mark2) return 62;
        return 0;
    endfunction

    function automatic int recv_idle_pct(input int sent);
        if (sent < mark1) return 62;
        if (sent < mark2) return 36;
        return 0;
    endfunction

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct(sent_count)) begin
                    next_item = stim_q.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= next_item.data;
                    s_tlast    <= next_item.last;
                    sent_count <= sent_count + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct(sent_count));
        end
    end

    always @(posedge aclk) begin
        idck_result_t got;
        idck_result_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached with %0d results outstanding",
                     results_due.size());
            $display("id_number_checksum_validator: mismatch");
            $finish;
        end
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = idck_result_t'(m_tdata[RES_W-1:0]);
                if (results_due.size() == 0) begin
                    report_mismatch("transaction with no pending expectation", 1, 0);
                end else begin
                    want = results_due.pop_front();
                    if (want.check_match) good_checks++;
                    if (got.form_ok !== want.form_ok)
                        report_mismatch("form_ok", got.form_ok, want.form_ok);
                    if (got.check_match !== want.check_match)
                        report_mismatch("check_match", got.check_match,
                                        want.check_match);
                    if (got.date_valid !== want.date_valid)
                        report_mismatch("date_valid", got.date_valid, want.date_valid);
                    if (got.birth_year !== want.birth_year)
                        report_mismatch("birth_year", got.birth_year, want.birth_year);
                    if (got.birth_month !== want.birth_month)
                        report_mismatch("birth_month", got.birth_month, want.birth_month);
                    if (got.birth_day !== want.birth_day)
                        report_mismatch("birth_day", got.birth_day, want.birth_day);
                    if (got.is_male !== want.is_male)
                        report_mismatch("is_male", got.is_male, want.is_male);
                    if (got.expected_check !== want.expected_check)
                        report_mismatch("expected_check", got.expected_check,
                                        want.expected_check);
                    if (got.cleaned_length !== want.cleaned_length)
                        report_mismatch("cleaned_length", got.cleaned_length,
                                        want.cleaned_length);
                    if (m_tdata[TDATA_OUT_W-1:RES_W] !== '0)
                        report_mismatch("zero fill", m_tdata[TDATA_OUT_W-1:RES_W], 0);
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata, s_tlast);
                bytes_in++;
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    initial begin
        int pick;
        clear_predictor();

        build_id(1'b1, 1'b1);
        compose_id(1'b1, 1);
        flush_string();
        push_raw(LEAD_BYTE, 1'b1);
        push_raw(LEAD_BYTE, 1'b0);
        push_raw(CHAR_UP_B, 1'b1);
        push_raw(8'h00, 1'b1);
        push_raw(8'hFF, 1'b1);
        strings_made += 4;

        while (stim_q.size() < RAW_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                build_id($urandom_range(3) == 0, $urandom_range(9) < 7);
                compose_id($urandom_range(1), $urandom_range(2));
                flush_string();
            end else if (pick < 85) begin
                build_id($urandom_range(3) == 0, $urandom_range(9) < 7);
                compose_id(1'b1, $urandom_range(2));
                corrupt_id();
                flush_string();
            end else begin
                repeat ($urandom_range(6, 1)) str_q.insert(str_q.size(), 8'($urandom_range(255)));
                flush_string();
            end
        end
        mark1 = stim_q.size() / 3;
        mark2 = 2 * stim_q.size() / 3;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (stim_q.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Streamed %0d raw bytes in %0d strings under three idle patterns.",
                 bytes_in, strings_made);
        $display("Checked %0d results, %0d of them with a matching check character.",
                 results_seen, good_checks);
        if (errors == 0) begin
            $display("id_number_checksum_validator: match");
        end else begin
            $display("id_number_checksum_validator: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
src/idck_pkg.sv
src/idck_step.sv
src/id_number_checksum_validator.sv
bench/id_number_checksum_validator_tb.sv
